[sv/hm_pkg.sv]
// package for the indexed min-heap core: widths, codes and memory request types
// no dependencies
package hm_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned KEY_W    = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned SLOT_W   = ADDR_W + 1;
  localparam int unsigned CHILD_W  = SLOT_W + 1;
  localparam int unsigned KEYS     = 2 ** KEY_W;
  localparam int unsigned ENTRY_W  = KEY_W + VALUE_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_DUP    = 2'd3
  } status_e;

  typedef struct packed {
    logic                re;
    logic [ADDR_W-1:0]   raddr;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ENTRY_W-1:0]  wdata;
  } heap_req_t;

  typedef struct packed {
    logic                re;
    logic [KEY_W-1:0]    raddr;
    logic                we;
    logic [KEY_W-1:0]    waddr;
    logic [SLOT_W-1:0]   wdata;
  } pos_req_t;

  typedef struct packed {
    logic                busy;
    logic                clearing;
    logic [SLOT_W-1:0]   count;
  } ctrl_stat_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CHILD_W-1:0] s);
    logic [CHILD_W-1:0] t;
    t = s - CHILD_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

[sv/hm_if.sv]
// stream interfaces for the indexed min-heap core: command beats in, result beats out
// depends on hm_pkg
interface hm_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [hm_pkg::KEY_W-1:0]  key;
  logic signed [hm_pkg::VALUE_W-1:0] value;
  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface hm_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [hm_pkg::KEY_W-1:0]  key_out;
  logic signed [hm_pkg::VALUE_W-1:0] value_out;
  modport source (output valid, status, key_out, value_out, input ready);
  modport sink   (input valid, status, key_out, value_out, output ready);
endinterface

[sv/hm_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module hm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/hm_ctrl.sv]
// sequencer of the indexed min-heap: membership test, sift up, walk up, sift down
// depends on hm_pkg and hm_if; drives the heap ram and the position map ram
module hm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hm_in_if.sink                         in_i,
  hm_out_if.source                      out_o,
  output hm_pkg::heap_req_t             heap_req_o,
  input  logic [hm_pkg::ENTRY_W-1:0]    heap_rdata_i,
  output hm_pkg::pos_req_t              pos_req_o,
  input  logic [hm_pkg::SLOT_W-1:0]     pos_rdata_i,
  output hm_pkg::ctrl_stat_t            stat_o
);

  localparam int unsigned KW = hm_pkg::KEY_W;
  localparam int unsigned VW = hm_pkg::VALUE_W;
  localparam int unsigned SW = hm_pkg::SLOT_W;
  localparam int unsigned CW = hm_pkg::CHILD_W;

  typedef enum logic [13:0] {
    S_CLR    = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_POS    = 14'b00000000000100,
    S_KEY    = 14'b00000000001000,
    S_UP     = 14'b00000000010000,
    S_UP_C   = 14'b00000000100000,
    S_RU     = 14'b00000001000000,
    S_RU_W   = 14'b00000010000000,
    S_POP    = 14'b00000100000000,
    S_LAST_R = 14'b00001000000000,
    S_LAST   = 14'b00010000000000,
    S_DN     = 14'b00100000000000,
    S_DN_A   = 14'b01000000000000,
    S_DN_B   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic dn_c_q, dn_c_d;
  hm_pkg::op_e op_q, op_d;
  logic [KW-1:0] key_q, key_d, lk_q, lk_d, ck_q, ck_d;
  logic signed [VW-1:0] val_q, val_d, lv_q, lv_d, cv_q, cv_d;
  logic [SW-1:0] count_q, count_d, hole_q, hole_d;
  logic [CW-1:0] c_q, c_d;
  logic [KW-1:0] clr_q, clr_d;
  logic out_valid_q, out_valid_d;
  hm_pkg::status_e status_q, status_d;
  logic [KW-1:0] kout_q, kout_d;
  logic signed [VW-1:0] vout_q, vout_d;

  logic [KW-1:0] rk;
  logic signed [VW-1:0] rv;
  logic [SW-1:0] parent;
  logic [CW-1:0] hole_x, count_x, c_inc;
  logic take;

  assign rk      = heap_rdata_i[hm_pkg::ENTRY_W-1:VW];
  assign rv      = heap_rdata_i[VW-1:0];
  assign parent  = hole_q >> 1;
  assign hole_x  = {1'b0, hole_q};
  assign count_x = {1'b0, count_q};
  assign c_inc   = c_q + CW'(1);
  assign take    = in_i.valid && in_i.ready;

  assign in_i.ready      = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.key_out   = kout_q;
  assign out_o.value_out = vout_q;

  assign stat_o.busy     = (state_q != S_IDLE);
  assign stat_o.clearing = (state_q == S_CLR);
  assign stat_o.count    = count_q;

  always_comb begin
    state_d     = state_q;
    dn_c_d      = 1'b0;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    lk_d        = lk_q;
    lv_d        = lv_q;
    ck_d        = ck_q;
    cv_d        = cv_q;
    count_d     = count_q;
    hole_d      = hole_q;
    c_d         = c_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    kout_d      = kout_q;
    vout_d      = vout_q;
    heap_req_o  = '0;
    pos_req_o   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        pos_req_o.we    = 1'b1;
        pos_req_o.waddr = clr_q;
        clr_d = clr_q + KW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          op_d   = hm_pkg::op_e'(in_i.operation);
          key_d  = in_i.key;
          val_d  = in_i.value;
          kout_d = '0;
          vout_d = '0;
          unique case (hm_pkg::op_e'(in_i.operation)) inside
            hm_pkg::OP_INSERT, hm_pkg::OP_REMOVE: begin
              pos_req_o.re    = 1'b1;
              pos_req_o.raddr = in_i.key;
              state_d = S_POS;
            end
            hm_pkg::OP_POP: begin
              if (count_q == '0) begin
                status_d    = hm_pkg::ST_ABSENT;
                out_valid_d = 1'b1;
              end else begin
                heap_req_o.re    = 1'b1;
                heap_req_o.raddr = hm_pkg::slot_addr(CW'(1));
                state_d = S_POP;
              end
            end
            default: begin
              count_d     = '0;
              status_d    = hm_pkg::ST_DONE;
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_POS: begin
        hole_d = pos_rdata_i;
        if (pos_rdata_i != '0 && pos_rdata_i <= count_q) begin
          heap_req_o.re    = 1'b1;
          heap_req_o.raddr = hm_pkg::slot_addr({1'b0, pos_rdata_i});
          state_d = S_KEY;
        end else if (op_q == hm_pkg::OP_REMOVE) begin
          status_d    = hm_pkg::ST_ABSENT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (count_x >= CW'(hm_pkg::CAPACITY)) begin
          status_d    = hm_pkg::ST_FULL;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          count_d = count_q + SW'(1);
          hole_d  = count_q + SW'(1);
          state_d = S_UP;
        end
      end
      S_KEY: begin
        if (rk == key_q) begin
          if (op_q == hm_pkg::OP_REMOVE) begin
            kout_d  = rk;
            vout_d  = rv;
            state_d = S_RU;
          end else begin
            status_d    = hm_pkg::ST_DUP;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (op_q == hm_pkg::OP_REMOVE) begin
          status_d    = hm_pkg::ST_ABSENT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (count_x >= CW'(hm_pkg::CAPACITY)) begin
          status_d    = hm_pkg::ST_FULL;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          count_d = count_q + SW'(1);
          hole_d  = count_q + SW'(1);
          state_d = S_UP;
        end
      end
      S_UP: begin
        if (hole_q > SW'(1)) begin
          heap_req_o.re    = 1'b1;
          heap_req_o.raddr = hm_pkg::slot_addr({1'b0, parent});
          state_d = S_UP_C;
        end else begin
          heap_req_o.we    = 1'b1;
          heap_req_o.waddr = hm_pkg::slot_addr(hole_x);
          heap_req_o.wdata = {key_q, val_q};
          pos_req_o.we     = 1'b1;
          pos_req_o.waddr  = key_q;
          pos_req_o.wdata  = hole_q;
          status_d    = hm_pkg::ST_DONE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_UP_C: begin
        heap_req_o.we    = 1'b1;
        heap_req_o.waddr = hm_pkg::slot_addr(hole_x);
        pos_req_o.we     = 1'b1;
        pos_req_o.wdata  = hole_q;
        if (val_q < rv) begin
          heap_req_o.wdata = heap_rdata_i;
          pos_req_o.waddr  = rk;
          hole_d  = parent;
          state_d = S_UP;
        end else begin
          heap_req_o.wdata = {key_q, val_q};
          pos_req_o.waddr  = key_q;
          status_d    = hm_pkg::ST_DONE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RU: begin
        if (hole_q > SW'(1)) begin
          heap_req_o.re    = 1'b1;
          heap_req_o.raddr = hm_pkg::slot_addr({1'b0, parent});
          state_d = S_RU_W;
        end else begin
          state_d = S_LAST_R;
        end
      end
      S_RU_W: begin
        heap_req_o.we    = 1'b1;
        heap_req_o.waddr = hm_pkg::slot_addr(hole_x);
        heap_req_o.wdata = heap_rdata_i;
        pos_req_o.we     = 1'b1;
        pos_req_o.waddr  = rk;
        pos_req_o.wdata  = hole_q;
        hole_d  = parent;
        state_d = S_RU;
      end
      S_POP: begin
        kout_d  = rk;
        vout_d  = rv;
        hole_d  = SW'(1);
        state_d = S_LAST_R;
      end
      S_LAST_R: begin
        heap_req_o.re    = 1'b1;
        heap_req_o.raddr = hm_pkg::slot_addr(count_x);
        state_d = S_LAST;
      end
      S_LAST: begin
        lk_d    = rk;
        lv_d    = rv;
        c_d     = CW'(2);
        state_d = S_DN;
      end
      S_DN: begin
        if (c_q < count_x && !dn_c_q) begin
          heap_req_o.re    = 1'b1;
          heap_req_o.raddr = hm_pkg::slot_addr(c_q);
          state_d = S_DN_A;
        end else if (dn_c_q && cv_q < lv_q) begin
          heap_req_o.we    = 1'b1;
          heap_req_o.waddr = hm_pkg::slot_addr(hole_x);
          heap_req_o.wdata = {ck_q, cv_q};
          pos_req_o.we     = 1'b1;
          pos_req_o.waddr  = ck_q;
          pos_req_o.wdata  = hole_q;
          hole_d = c_q[SW-1:0];
          c_d    = c_q << 1;
        end else begin
          heap_req_o.we    = 1'b1;
          heap_req_o.waddr = hm_pkg::slot_addr(hole_x);
          heap_req_o.wdata = {lk_q, lv_q};
          pos_req_o.we     = 1'b1;
          pos_req_o.waddr  = lk_q;
          pos_req_o.wdata  = hole_q;
          count_d     = count_q - SW'(1);
          status_d    = hm_pkg::ST_DONE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DN_A: begin
        ck_d = rk;
        cv_d = rv;
        if (c_inc < count_x) begin
          heap_req_o.re    = 1'b1;
          heap_req_o.raddr = hm_pkg::slot_addr(c_inc);
          state_d = S_DN_B;
        end else begin
          dn_c_d  = 1'b1;
          state_d = S_DN;
        end
      end
      S_DN_B: begin
        if (rv < cv_q) begin
          ck_d = rk;
          cv_d = rv;
          c_d  = c_inc;
        end
        dn_c_d  = 1'b1;
        state_d = S_DN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      dn_c_q      <= 1'b0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dn_c_q      <= dn_c_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    lk_q     <= lk_d;
    lv_q     <= lv_d;
    ck_q     <= ck_d;
    cv_q     <= cv_d;
    hole_q   <= hole_d;
    c_q      <= c_d;
    status_q <= status_d;
    kout_q   <= kout_d;
    vout_q   <= vout_d;
  end

endmodule

[sv/indexed_min_heap_core.sv]
// top level of the indexed min-heap core: sequencer plus heap ram and position map ram
// depends on hm_pkg, hm_if, hm_ram and hm_ctrl
//
// usage:
// - in_i carries one command beat: operation (insert, remove by key, pop minimum,
//   clear), key and a signed value; out_o returns one result beat per command
//   with status, key_out and value_out
// - one command is in flight at a time; a new beat is taken once the previous
//   one is finished and the result register is free or being emptied
// - insert sifts the new entry up level by level; remove walks its hole up to the
//   root, then pop and remove sift the last entry down from the root
// - the heap ram has a single read port: every level of a sift costs a read, a
//   compare and a write-back
// - after reset the position map is cleared one entry per cycle, all 1024 entries,
//   with in_i.ready low; the heap comes up empty
// - when the receiver holds out_o.ready low the result beat stays in its
//   register and no further command is taken until it drains
module indexed_min_heap_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  hm_in_if.sink     in_i,
  hm_out_if.source  out_o
);

  hm_pkg::heap_req_t  heap_req;
  hm_pkg::pos_req_t   pos_req;
  hm_pkg::ctrl_stat_t stat;
  logic [hm_pkg::ENTRY_W-1:0] heap_rdata;
  logic [hm_pkg::SLOT_W-1:0]  pos_rdata;

  hm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .heap_req_o   (heap_req),
    .heap_rdata_i (heap_rdata),
    .pos_req_o    (pos_req),
    .pos_rdata_i  (pos_rdata),
    .stat_o       (stat)
  );

  hm_ram #(
    .DEPTH (hm_pkg::CAPACITY),
    .WIDTH (hm_pkg::ENTRY_W)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_req.we),
    .waddr_i (heap_req.waddr),
    .wdata_i (heap_req.wdata),
    .re_i    (heap_req.re),
    .raddr_i (heap_req.raddr),
    .rdata_o (heap_rdata)
  );

  hm_ram #(
    .DEPTH (hm_pkg::KEYS),
    .WIDTH (hm_pkg::SLOT_W)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_req.we),
    .waddr_i (pos_req.waddr),
    .wdata_i (pos_req.wdata),
    .re_i    (pos_req.re),
    .raddr_i (pos_req.raddr),
    .rdata_o (pos_rdata)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= hm_pkg::SLOT_W'(hm_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.operation == hm_pkg::OP_CLEAR |=> stat.count == '0)
    else $error("clear left entries");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != hm_pkg::ST_DONE |-> out_o.key_out == '0 &&
    out_o.value_out == '0)
    else $error("failed result carries payload");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !in_i.ready)
    else $error("command taken while busy");

  a_map_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> stat.count == '0 && !out_o.valid)
    else $error("activity during position map clear");
`endif

endmodule
